FILE: src/slip_fd_pkg.sv
// ----------------------------------------------------------------------------
// slip_fd_pkg - shared types and constants for the SLIP frame decoder
// Item layouts for both channels, line codes and event codes.
// ----------------------------------------------------------------------------
package slip_fd_pkg;

	// Line codes
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;
	localparam logic [7:0] ABORT_CHAR   = 8'h1B;

	// Saturation limit of the abort escape counter
	localparam logic [3:0] ABORT_CNT_MAX = 4'hF;

	// Event codes
	localparam logic [2:0] EV_DATA     = 3'd0;
	localparam logic [2:0] EV_DONE     = 3'd1;
	localparam logic [2:0] EV_RUNT     = 3'd2;
	localparam logic [2:0] EV_OVERFLOW = 3'd3;
	localparam logic [2:0] EV_ABORT    = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] CFG_ABORT_ENABLE = 3'd0;
	localparam logic [2:0] CFG_ABORT_IDLE   = 3'd1;
	localparam logic [2:0] CFG_ABORT_WINDOW = 3'd2;
	localparam logic [2:0] CFG_ABORT_NEEDED = 3'd3;
	localparam logic [2:0] CFG_MIN_LEN      = 3'd4;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] now_sec;
		logic        carrier_on;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  data_byte;
		logic [10:0] write_index;
		logic [11:0] frame_length;
		logic [7:0]  first_byte;
	} out_item_t;

endpackage

FILE: src/slip_frame_decoder.sv
// ----------------------------------------------------------------------------
// slip_frame_decoder - SLIP receive deframer with escape abort detector
// Decodes escaped line bytes into data events and frame end events.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one raw line byte per item, with a seconds timestamp and the
//            carrier flag. Items taken with carrier off change nothing and
//            produce no result.
//   out_*  : at most one event item per input item: data byte with its
//            index, frame complete, runt, overflow or abort.
//   cfg_*  : register writes (index 0..4); always ready. Write only while
//            the block is idle. Indexes past the list are dropped.
// Output: an item's event is loaded into the output register by the clock
//   edge that accepts the item.
// Throughput: one item per cycle while the output register can take it. The decode and the abort timing checks
//   are a single pass of logic from the state registers to the output
//   register, so the state is current for the very next item.
// Stall: in_ready falls only while an event sits in the output register
//   and out_ready is low; the register is refilled on the cycle it drains.
// Reset: arst_n clears the framer, the abort counter, the timestamps and
//   the output valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module slip_frame_decoder #(
	parameter int MAX_FRAME = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  slip_fd_pkg::in_item_t in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output slip_fd_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [7:0]            cfg_wdata
);

	// fill count must hold MAX_FRAME itself
	localparam int FW = $clog2(MAX_FRAME + 1);

	// configuration
	logic        abort_en_q;
	logic [7:0]  idle_sec_q;
	logic [7:0]  window_sec_q;
	logic [3:0]  needed_q;
	logic [7:0]  min_len_q;

	// framer and abort state
	logic          esc_q;
	logic [FW-1:0] fill_q;
	logic [7:0]    first_q;
	logic [3:0]    abort_cnt_q;
	logic [31:0]   last_time_q;
	logic [31:0]   first_esc_time_q;

	logic in_fire;

	// abort detector datapath
	logic        idle;
	logic        esc_hit;
	logic [3:0]  cnt_inc;
	logic [31:0] first_esc_nxt;
	logic        win_expired;
	logic [3:0]  cnt_win;
	logic        abort;

	// framer datapath
	logic [7:0]          dec_byte;
	logic                has_room;
	logic                is_runt;
	slip_fd_pkg::out_item_t res;
	logic                res_valid;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;

	// ---- abort detector: idle-separated ESC count inside a time window
	always_comb begin
		idle    = (in_data.now_sec - last_time_q) >= {24'd0, idle_sec_q};
		esc_hit = (in_data.rx_byte == slip_fd_pkg::ABORT_CHAR) && idle;
		cnt_inc = abort_cnt_q;
		if (esc_hit && abort_cnt_q != slip_fd_pkg::ABORT_CNT_MAX) begin
			cnt_inc = abort_cnt_q + 4'd1;
		end
		// stamp the window start on the first counted escape
		first_esc_nxt = (esc_hit && cnt_inc == 4'd1) ? in_data.now_sec : first_esc_time_q;
		win_expired   = (in_data.now_sec - first_esc_nxt) >= {24'd0, window_sec_q};
		cnt_win       = (cnt_inc != 4'd0 && win_expired) ? 4'd0 : cnt_inc;
		abort = abort_en_q && cnt_win != 4'd0 && cnt_win >= needed_q && idle;
	end

	// ---- framer
	always_comb begin
		dec_byte = in_data.rx_byte;
		if (esc_q) begin
			if (in_data.rx_byte == slip_fd_pkg::SLIP_ESC_ESC) begin
				dec_byte = slip_fd_pkg::SLIP_ESC;
			end else if (in_data.rx_byte == slip_fd_pkg::SLIP_ESC_END) begin
				dec_byte = slip_fd_pkg::SLIP_END;
			end
		end
		has_room = fill_q < FW'(MAX_FRAME);
		is_runt  = 32'(fill_q) < 32'(min_len_q);

		res       = '0;
		res_valid = 1'b0;
		if (!in_data.carrier_on) begin
			res_valid = 1'b0;
		end else if (abort) begin
			res_valid      = 1'b1;
			res.event_kind = slip_fd_pkg::EV_ABORT;
		end else if (in_data.rx_byte == slip_fd_pkg::SLIP_ESC) begin
			res_valid = 1'b0;
		end else if (in_data.rx_byte == slip_fd_pkg::SLIP_END) begin
			res_valid        = 1'b1;
			res.frame_length = 12'(fill_q);
			if (is_runt) begin
				res.event_kind = slip_fd_pkg::EV_RUNT;
			end else begin
				res.event_kind = slip_fd_pkg::EV_DONE;
				res.first_byte = first_q;
			end
		end else if (has_room) begin
			res_valid       = 1'b1;
			res.event_kind  = slip_fd_pkg::EV_DATA;
			res.data_byte   = dec_byte;
			res.write_index = 11'(fill_q);
		end else begin
			res_valid      = 1'b1;
			res.event_kind = slip_fd_pkg::EV_OVERFLOW;
		end
	end

	// ---- configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abort_en_q   <= 1'b0;
			idle_sec_q   <= 8'd1;
			window_sec_q <= 8'd12;
			needed_q     <= 4'd3;
			min_len_q    <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				slip_fd_pkg::CFG_ABORT_ENABLE: abort_en_q   <= cfg_wdata[0];
				slip_fd_pkg::CFG_ABORT_IDLE:   idle_sec_q   <= cfg_wdata;
				slip_fd_pkg::CFG_ABORT_WINDOW: window_sec_q <= cfg_wdata;
				slip_fd_pkg::CFG_ABORT_NEEDED: needed_q     <= cfg_wdata[3:0];
				slip_fd_pkg::CFG_MIN_LEN:      min_len_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---- abort detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abort_cnt_q      <= '0;
			last_time_q      <= '0;
			first_esc_time_q <= '0;
		end else if (in_fire && in_data.carrier_on && abort_en_q) begin
			first_esc_time_q <= first_esc_nxt;
			abort_cnt_q      <= abort ? 4'd0 : cnt_win;
			// the aborting byte does not refresh the idle stamp
			if (!abort) begin
				last_time_q <= in_data.now_sec;
			end
		end
	end

	// ---- framer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			fill_q  <= '0;
			first_q <= '0;
		end else if (in_fire && in_data.carrier_on) begin
			if (abort || in_data.rx_byte == slip_fd_pkg::SLIP_END || (
			    in_data.rx_byte != slip_fd_pkg::SLIP_ESC && !has_room)) begin
				// abort, frame end or overflow: restart the frame
				esc_q   <= 1'b0;
				fill_q  <= '0;
				first_q <= '0;
			end else if (in_data.rx_byte == slip_fd_pkg::SLIP_ESC) begin
				esc_q <= 1'b1;
			end else begin
				esc_q  <= 1'b0;
				fill_q <= fill_q + FW'(1);
				if (fill_q == '0) begin
					first_q <= dec_byte;
				end
			end
		end
	end

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res_valid) begin
			out_data <= res;
		end
	end

	// ---- assertions
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.carrier_on && in_data.rx_byte == slip_fd_pkg::SLIP_END
		|=> fill_q == '0 && !esc_q)
		else $error("frame end did not restart the framer");

	a_abort_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.carrier_on && abort
		|=> abort_cnt_q == 4'd0 && fill_q == '0 && out_valid &&
		    out_data.event_kind == slip_fd_pkg::EV_ABORT)
		else $error("abort did not clear counter and framer");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind == slip_fd_pkg::EV_DATA &&
		out_data.write_index == 11'd0 && fill_q == FW'(1)
		|-> first_q == out_data.data_byte)
		else $error("first stored byte mismatch");

	a_no_carrier_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !in_data.carrier_on |=> !out_valid && $stable(fill_q))
		else $error("byte without carrier produced an event");

endmodule

FILE: dv/slip_fd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slip_fd_checker - event predictor and scoreboard for the SLIP decoder
// Watches the input, event and register channels, keeps its own copy of the
// decoder state and registers, and compares every accepted event, field by
// field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module slip_fd_checker #(
	parameter int MAX_FRAME = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  slip_fd_pkg::in_item_t  in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  slip_fd_pkg::out_item_t out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [7:0]             cfg_wdata,
	output int                     fail_count,
	output int                     events_pending
);

	// register copy
	logic        abort_on;
	logic [7:0]  idle_sec;
	logic [7:0]  window_sec;
	logic [3:0]  esc_needed;
	logic [7:0]  min_len;

	// decoder state copy
	logic        esc_armed;
	logic [12:0] fill;
	logic [7:0]  first_kept;
	logic [3:0]  esc_count;
	logic [31:0] last_stamp;
	logic [31:0] first_esc_stamp;

	slip_fd_pkg::out_item_t expected_events[$];
	slip_fd_pkg::out_item_t next_ev;
	slip_fd_pkg::out_item_t want_ev;
	bit                     has_ev;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic clear_frame();
		fill       = '0;
		esc_armed  = 1'b0;
		first_kept = '0;
	endtask

	task automatic decode_byte(input slip_fd_pkg::in_item_t it, output bit produced,
			output slip_fd_pkg::out_item_t ev);
		logic [7:0]  c;
		logic [31:0] since_last;
		logic [31:0] since_first;
		bit          idle_gap;
		produced = 1'b0;
		ev       = '0;
		c        = it.rx_byte;
		if (!it.carrier_on)
			return;

		if (abort_on) begin
			since_last = it.now_sec - last_stamp;
			idle_gap   = since_last >= {24'd0, idle_sec};
			if (c == slip_fd_pkg::ABORT_CHAR && idle_gap) begin
				if (esc_count != slip_fd_pkg::ABORT_CNT_MAX)
					esc_count++;
				if (esc_count == 4'd1)
					first_esc_stamp = it.now_sec;
			end
			if (esc_count != 4'd0) begin
				since_first = it.now_sec - first_esc_stamp;
				if (since_first >= {24'd0, window_sec})
					esc_count = '0;
				if (esc_count != 4'd0 && esc_count >= esc_needed && idle_gap) begin
					// abort: framer restarts, timestamp left alone
					clear_frame();
					esc_count     = '0;
					produced      = 1'b1;
					ev.event_kind = slip_fd_pkg::EV_ABORT;
					return;
				end
			end
			last_stamp = it.now_sec;
		end

		if (c == slip_fd_pkg::SLIP_ESC) begin
			esc_armed = 1'b1;
			return;
		end
		if (c == slip_fd_pkg::SLIP_END) begin
			produced        = 1'b1;
			ev.frame_length = fill[11:0];
			if (fill < {5'd0, min_len}) begin
				ev.event_kind = slip_fd_pkg::EV_RUNT;
			end else begin
				ev.event_kind = slip_fd_pkg::EV_DONE;
				ev.first_byte = first_kept;
			end
			clear_frame();
			return;
		end
		if (esc_armed) begin
			if (c == slip_fd_pkg::SLIP_ESC_ESC)
				c = slip_fd_pkg::SLIP_ESC;
			else if (c == slip_fd_pkg::SLIP_ESC_END)
				c = slip_fd_pkg::SLIP_END;
		end
		produced = 1'b1;
		if (fill < 13'(MAX_FRAME)) begin
			if (fill == '0)
				first_kept = c;
			ev.event_kind  = slip_fd_pkg::EV_DATA;
			ev.data_byte   = c;
			ev.write_index = fill[10:0];
			fill++;
			esc_armed = 1'b0;
		end else begin
			clear_frame();
			ev.event_kind = slip_fd_pkg::EV_OVERFLOW;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abort_on        = 1'b0;
			idle_sec        = 8'd1;
			window_sec      = 8'd12;
			esc_needed      = 4'd3;
			min_len         = 8'd3;
			clear_frame();
			esc_count       = '0;
			last_stamp      = '0;
			first_esc_stamp = '0;
			expected_events.delete();
			events_pending  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					slip_fd_pkg::CFG_ABORT_ENABLE: abort_on   = cfg_wdata[0];
					slip_fd_pkg::CFG_ABORT_IDLE:   idle_sec   = cfg_wdata;
					slip_fd_pkg::CFG_ABORT_WINDOW: window_sec = cfg_wdata;
					slip_fd_pkg::CFG_ABORT_NEEDED: esc_needed = cfg_wdata[3:0];
					slip_fd_pkg::CFG_MIN_LEN:      min_len    = cfg_wdata;
					default: ;
				endcase
			end
			// an event leaving now belongs to an earlier item, so pop first
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("event kind %0d with nothing expected",
						out_data.event_kind));
				end else begin
					want_ev = expected_events.pop_front();
					check_field("event_kind", 32'(out_data.event_kind),
						32'(want_ev.event_kind));
					check_field("data_byte", 32'(out_data.data_byte),
						32'(want_ev.data_byte));
					check_field("write_index", 32'(out_data.write_index),
						32'(want_ev.write_index));
					check_field("frame_length", 32'(out_data.frame_length),
						32'(want_ev.frame_length));
					check_field("first_byte", 32'(out_data.first_byte),
						32'(want_ev.first_byte));
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(in_data, has_ev, next_ev);
				if (has_ev)
					expected_events.push_back(next_ev);
			end
			events_pending = expected_events.size();
		end
	end

endmodule

FILE: dv/slip_frame_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slip_frame_decoder_tb - stimulus and verdict for the SLIP frame decoder
// Drives line bytes, register writes and event back-pressure; the checker
// beside the decoder predicts and compares. Directed bytes first, then random
// frames, abort sequences and noise under several register and idle settings.
// ----------------------------------------------------------------------------
module slip_frame_decoder_tb;

	localparam int MAX_FRAME      = 2048;
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 4;     // margin after the output drains
	localparam int PHASE_ITEMS    = 280;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	slip_fd_pkg::in_item_t  in_data   = '0;
	logic                   in_ready;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	slip_fd_pkg::out_item_t out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [2:0]             cfg_index = '0;
	logic [7:0]             cfg_wdata = '0;

	int fail_count;
	int events_pending;

	// knobs shared with the receiver process
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_req       = 1'b0;

	logic [31:0] line_time = '0;   // seconds stamp of the simulated line
	logic [7:0]  cur_idle  = 8'd1; // idle register as last written
	int          carried_items;    // items with carrier on, this phase
	int          quiet_cycles = 0;

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	slip_frame_decoder #(
		.MAX_FRAME(MAX_FRAME)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	slip_fd_checker #(
		.MAX_FRAME(MAX_FRAME)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.events_pending(events_pending)
	);

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Event receiver: random stalls, plus one long hold-off on request so the
	// output register fills and the decoder has to stall its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one line byte. Entered and left at a falling edge; valid stays
	// high across back-to-back items and only drops for a sender gap.
	task automatic send_byte(input logic [7:0] b, input logic [31:0] stamp,
			input logic car);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{rx_byte: b, now_sec: stamp, carrier_on: car};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (car)
			carried_items++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Raw write data: values wider than a register get masked by the block.
	task automatic apply_config(input logic [7:0] en, input logic [7:0] idle,
			input logic [7:0] win, input logic [7:0] need, input logic [7:0] minl,
			input bit extra);
		int k;
		write_reg(slip_fd_pkg::CFG_ABORT_ENABLE, en);
		write_reg(slip_fd_pkg::CFG_ABORT_IDLE, idle);
		write_reg(slip_fd_pkg::CFG_ABORT_WINDOW, win);
		write_reg(slip_fd_pkg::CFG_ABORT_NEEDED, need);
		write_reg(slip_fd_pkg::CFG_MIN_LEN, minl);
		// indexes past the register list must be ignored
		if (extra)
			for (k = int'(slip_fd_pkg::CFG_MIN_LEN) + 1; k < 8; k++)
				write_reg(3'(k), 8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
		cur_idle = idle;
	endtask

	// Drop valid, wait until every predicted event is out, then add a settle margin.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (events_pending != 0 || out_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Frame with random content, escapes and the odd byte lost
	// to a carrier drop, closed by an END.
	task automatic send_frame(input int len);
		int         i;
		logic [7:0] b;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0)
				line_time += 1;
			case ($urandom_range(0, 19)) inside
				0: send_byte(8'($urandom_range(0, 255)), line_time, 1'b0);
				1, 2: begin
					send_byte(slip_fd_pkg::SLIP_ESC, line_time, 1'b1);
					case ($urandom_range(0, 3))
						0: b = slip_fd_pkg::SLIP_ESC_END;
						1: b = slip_fd_pkg::SLIP_ESC_ESC;
						2: b = slip_fd_pkg::SLIP_ESC;
						default: b = 8'($urandom_range(0, 255));
					endcase
					send_byte(b, line_time, 1'b1);
				end
				default: send_byte(8'($urandom_range(0, 255)), line_time, 1'b1);
			endcase
		end
		send_byte(slip_fd_pkg::SLIP_END, line_time, 1'b1);
	endtask

	// ESC characters spaced by the idle time, mostly; some spacing is
	// skipped and some stray bytes slip in to break the sequence.
	task automatic send_abort_run();
		int n;
		int i;
		n = $urandom_range(1, 16);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) != 0)
				line_time += cur_idle + $urandom_range(0, 3);
			send_byte(slip_fd_pkg::ABORT_CHAR, line_time, 1'b1);
			if ($urandom_range(0, 5) == 0)
				send_byte(8'($urandom_range(0, 255)), line_time, 1'b1);
		end
		line_time += cur_idle + $urandom_range(0, 2);
		send_byte(8'($urandom_range(0, 255)), line_time, 1'b1);
	endtask

	// Anything goes: random bytes, time jumps (near wrap too), carrier drops.
	task automatic send_noise();
		int n;
		int i;
		n = $urandom_range(1, 4);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: line_time = $urandom;
				1: line_time = 32'hFFFF_FFFF - $urandom_range(0, 300);
				default: line_time += $urandom_range(0, 20);
			endcase
			send_byte(8'($urandom_range(0, 255)), line_time, $urandom_range(0, 2) != 0);
		end
	endtask

	task automatic run_phase(input int snd_pct, input int rcv_pct, input int quota,
			input bit with_hold);
		bit held;
		int r;
		held           = 1'b0;
		send_idle_pct  = snd_pct;
		recv_stall_pct = rcv_pct;
		carried_items  = 0;
		while (carried_items < quota) begin
			if (with_hold && !held && carried_items >= quota / 2) begin
				hold_req = 1'b1;
				held     = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 55)
				send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
					: $urandom_range(0, 12));
			else if (r < 80)
				send_abort_run();
			else
				send_noise();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed, reset registers: abort off, minimum length 3 ---
		send_byte(slip_fd_pkg::SLIP_END, 32'd0, 1'b0);     // carrier off: ignored
		send_byte(8'h00, 32'd1, 1'b1);
		send_byte(8'hFF, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);     // escaped END
		send_byte(slip_fd_pkg::SLIP_ESC_END, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);     // escaped ESC
		send_byte(slip_fd_pkg::SLIP_ESC_ESC, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);     // repeated ESC stays armed
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);
		send_byte(8'h41, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);     // ESC before an ordinary byte
		send_byte(8'h55, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_END, 32'd1, 1'b1);     // complete frame
		send_byte(slip_fd_pkg::SLIP_END, 32'd1, 1'b1);     // empty runt
		send_byte(8'h11, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_END, 32'd1, 1'b1);     // one-byte runt
		send_byte(slip_fd_pkg::SLIP_ESC, 32'd1, 1'b1);     // ESC then END ends the frame
		send_byte(slip_fd_pkg::SLIP_END, 32'd1, 1'b1);
		send_byte(slip_fd_pkg::SLIP_ESC_END, 32'd1, 1'b1); // escape cleared: plain byte
		send_byte(slip_fd_pkg::SLIP_END, 32'd1, 1'b1);
		settle_block();

		// --- abort detector on: three idle-spaced ESCs trigger an abort ---
		apply_config(8'h01, 8'd1, 8'd12, 8'd3, 8'd3, 1'b0);
		send_byte(8'h33, 32'd99, 1'b1);
		send_byte(slip_fd_pkg::ABORT_CHAR, 32'd100, 1'b1);
		send_byte(slip_fd_pkg::ABORT_CHAR, 32'd101, 1'b1);
		send_byte(slip_fd_pkg::ABORT_CHAR, 32'd102, 1'b1);
		send_byte(slip_fd_pkg::ABORT_CHAR, 32'd102, 1'b1); // idle stamp not refreshed by the abort: counted, still data
		line_time = 32'd200;

		// --- random phases, one register setting each ---
		run_phase(0, 0, PHASE_ITEMS, 1'b1);      // with the long hold-off
		settle_block();

		// zero idle, zero window (count cleared at once), shortest settings
		apply_config(8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 1'b0);
		run_phase(61, 0, PHASE_ITEMS, 1'b0);
		settle_block();

		// longest window and count, every frame a runt
		apply_config(8'h01, 8'd2, 8'hFF, 8'h0F, 8'hFF, 1'b0);
		run_phase(0, 61, PHASE_ITEMS, 1'b0);
		settle_block();

		// longest idle, needed count written as zero, writes past the list
		apply_config(8'h03, 8'hFF, 8'd200, 8'hF0, 8'($urandom_range(0, 20)), 1'b1);
		run_phase(11, 11, PHASE_ITEMS, 1'b0);
		settle_block();

		if (fail_count == 0 && events_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
src/slip_fd_pkg.sv
src/slip_frame_decoder.sv
dv/slip_fd_checker.sv
dv/slip_frame_decoder_tb.sv
